FILE: src/lasi_pkg.sv
// ----------------------------------------------------------------------------
// lasi_pkg
// shared codes, register map and move tables of the line/arc step interpolator
// ----------------------------------------------------------------------------
package lasi_pkg;

    // item opcodes, the load opcodes double as move modes
    localparam logic [1:0] OP_LOAD_LINE = 2'd0;
    localparam logic [1:0] OP_LOAD_CW   = 2'd1;
    localparam logic [1:0] OP_LOAD_CCW  = 2'd2;
    localparam logic [1:0] OP_STEP      = 2'd3;

    localparam logic [1:0] MODE_LINE = OP_LOAD_LINE;
    localparam logic [1:0] MODE_CCW  = OP_LOAD_CCW;

    // move codes: bit 1 axis (0 x, 1 y), bit 0 negative
    localparam logic [1:0] MV_X_POS = 2'd0;
    localparam logic [1:0] MV_X_NEG = 2'd1;
    localparam logic [1:0] MV_Y_POS = 2'd2;
    localparam logic [1:0] MV_Y_NEG = 2'd3;

    // quadrant of the tool around the arc centre
    localparam logic [1:0] QUAD_PX_NY = 2'd0;
    localparam logic [1:0] QUAD_NX_NY = 2'd1;
    localparam logic [1:0] QUAD_NX_PY = 2'd2;
    localparam logic [1:0] QUAD_OTHER = 2'd3;

    // arc move table, indexed [ccw][f negative][quadrant]
    localparam logic [1:0] ARC_MOVE [2][2][4] = '{
        '{ '{MV_X_NEG, MV_Y_POS, MV_X_POS, MV_Y_NEG},
           '{MV_Y_NEG, MV_X_NEG, MV_Y_POS, MV_X_POS} },
        '{ '{MV_Y_POS, MV_X_POS, MV_Y_NEG, MV_X_NEG},
           '{MV_X_POS, MV_Y_NEG, MV_X_NEG, MV_Y_POS} }
    };

    // configuration register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_ARC_STEP_LIMIT = 1'b0;

    localparam int LIMIT_W = 18;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    // result side flags
    localparam int OUT_USER_W = 4;

    typedef struct packed {
        logic step_axis;
        logic step_negative;
        logic moved;
        logic last;
        logic overrun;
    } step_flags_t;

endpackage

FILE: src/lasi_apb.sv
// ----------------------------------------------------------------------------
// lasi_apb
// configuration register file behind an apb-style port
// ----------------------------------------------------------------------------
module lasi_apb
    import lasi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    arc_step_limit
);

    logic [LIMIT_W-1:0]   limit_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en && (reg_idx == REG_ARC_STEP_LIMIT))
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ARC_STEP_LIMIT: prdata = APB_DATA_W'(limit_reg);
            default:            prdata = '0;
        endcase
    end

    assign arc_step_limit = limit_reg;

endmodule

FILE: src/lasi_load.sv
// ----------------------------------------------------------------------------
// lasi_load
// move setup: step count of a line, squared end radius of an arc
// ----------------------------------------------------------------------------
module lasi_load
    import lasi_pkg::*;
#(
    parameter int CW = 16,
    parameter int FW = 36,
    parameter int SW = 18
)
(
    input  logic [1:0]         opcode,
    input  logic [CW-1:0]      start_x,
    input  logic [CW-1:0]      start_y,
    input  logic [CW-1:0]      end_x,
    input  logic [CW-1:0]      end_y,
    input  logic [CW-1:0]      center_x,
    input  logic [CW-1:0]      center_y,
    input  logic [LIMIT_W-1:0] arc_step_limit,
    output logic [FW-1:0]      radius_sq,
    output logic [SW-1:0]      steps_init,
    output logic               active_init
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx, dy, rx, ry;
    logic        [DW-1:0] adx, ady;
    logic signed [PW-1:0] rx_sq, ry_sq;
    logic        [SW-1:0] line_steps;
    logic                 is_line;

    assign is_line = (opcode == OP_LOAD_LINE);

    assign dx = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
    assign dy = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
    assign rx = $signed({end_x[CW-1], end_x}) - $signed({center_x[CW-1], center_x});
    assign ry = $signed({end_y[CW-1], end_y}) - $signed({center_y[CW-1], center_y});

    assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign line_steps = SW'(adx) + SW'(ady);

    assign rx_sq = rx * rx;
    assign ry_sq = ry * ry;

    always_comb
    begin
        if (is_line)
        begin
            radius_sq   = '0;
            steps_init  = line_steps;
            active_init = (line_steps != '0);
        end
        else
        begin
            radius_sq   = FW'(rx_sq) + FW'(ry_sq);
            steps_init  = SW'(arc_step_limit);
            active_init = (start_x != end_x) || (start_y != end_y);
        end
    end

endmodule

FILE: src/lasi_step.sv
// ----------------------------------------------------------------------------
// lasi_step
// one interpolation step: deviation sign, move choice and end test
// ----------------------------------------------------------------------------
module lasi_step
    import lasi_pkg::*;
#(
    parameter int CW = 16,
    parameter int FW = 36,
    parameter int SW = 18
)
(
    input  logic [1:0]    mode,
    input  logic [CW-1:0] cur_x,
    input  logic [CW-1:0] cur_y,
    input  logic [CW-1:0] org_x,
    input  logic [CW-1:0] org_y,
    input  logic [CW-1:0] tgt_x,
    input  logic [CW-1:0] tgt_y,
    input  logic [CW-1:0] ctr_x,
    input  logic [CW-1:0] ctr_y,
    input  logic [FW-1:0] radius_sq,
    input  logic [SW-1:0] steps_rem,
    output logic [CW-1:0] next_x,
    output logic [CW-1:0] next_y,
    output logic [SW-1:0] next_steps,
    output step_flags_t   flags
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx, dy, lpx, lpy, apx, apy;
    logic signed [DW-1:0] mul_a1, mul_b1, mul_a2, mul_b2;
    logic signed [PW-1:0] prod1, prod2;
    logic signed [FW-1:0] dev;
    logic                 is_line, ccw, dev_neg, reached, near_limit;
    logic [1:0]           quad, line_mv, mv;

    assign is_line = (mode == MODE_LINE);
    assign ccw     = (mode == MODE_CCW);

    assign dx  = $signed({tgt_x[CW-1], tgt_x}) - $signed({org_x[CW-1], org_x});
    assign dy  = $signed({tgt_y[CW-1], tgt_y}) - $signed({org_y[CW-1], org_y});
    assign lpx = $signed({cur_x[CW-1], cur_x}) - $signed({org_x[CW-1], org_x});
    assign lpy = $signed({cur_y[CW-1], cur_y}) - $signed({org_y[CW-1], org_y});
    assign apx = $signed({cur_x[CW-1], cur_x}) - $signed({ctr_x[CW-1], ctr_x});
    assign apy = $signed({cur_y[CW-1], cur_y}) - $signed({ctr_y[CW-1], ctr_y});

    // two shared multipliers: cross product terms for a line, squares for an arc
    always_comb
    begin
        if (is_line)
        begin
            mul_a1 = dx;
            mul_b1 = lpy;
            mul_a2 = lpx;
            mul_b2 = dy;
        end
        else
        begin
            mul_a1 = apx;
            mul_b1 = apx;
            mul_a2 = apy;
            mul_b2 = apy;
        end
    end

    assign prod1 = mul_a1 * mul_b1;
    assign prod2 = mul_a2 * mul_b2;

    assign dev = is_line ? (FW'(prod1) - FW'(prod2))
                         : (FW'(prod1) + FW'(prod2) - $signed(radius_sq));
    assign dev_neg = dev[FW-1];

    always_comb
    begin
        if (apx >= 0 && apy <= 0)
            quad = QUAD_PX_NY;
        else if (apx <= 0 && apy <= 0)
            quad = QUAD_NX_NY;
        else if (apx <= 0 && apy >= 0)
            quad = QUAD_NX_PY;
        else
            quad = QUAD_OTHER;
    end

    // horizontal and vertical lines step one axis only
    always_comb
    begin
        if (dy == 0)
            line_mv = (dx > 0) ? MV_X_POS : MV_X_NEG;
        else if (dx == 0)
            line_mv = (dy > 0) ? MV_Y_POS : MV_Y_NEG;
        else if (!dev_neg)
        begin
            if (dx > 0)
                line_mv = (dy > 0) ? MV_X_POS : MV_Y_NEG;
            else
                line_mv = (dy > 0) ? MV_Y_POS : MV_X_NEG;
        end
        else
        begin
            if (dy > 0)
                line_mv = (dx > 0) ? MV_Y_POS : MV_X_NEG;
            else
                line_mv = (dx > 0) ? MV_X_POS : MV_Y_NEG;
        end
    end

    assign mv = is_line ? line_mv : ARC_MOVE[ccw][dev_neg][quad];

    always_comb
    begin
        next_x = cur_x;
        next_y = cur_y;
        if (mv[1])
            next_y = mv[0] ? (cur_y - CW'(1)) : (cur_y + CW'(1));
        else
            next_x = mv[0] ? (cur_x - CW'(1)) : (cur_x + CW'(1));
    end

    assign reached    = (next_x == tgt_x) && (next_y == tgt_y);
    assign near_limit = (steps_rem <= SW'(1));
    assign next_steps = (steps_rem != '0) ? (steps_rem - SW'(1)) : steps_rem;

    always_comb
    begin
        flags.step_axis     = mv[1];
        flags.step_negative = mv[0];
        flags.moved         = 1'b1;
        if (is_line)
        begin
            flags.last    = (next_steps == '0);
            flags.overrun = 1'b0;
        end
        else
        begin
            flags.last    = reached || near_limit;
            flags.overrun = !reached && near_limit;
        end
    end

endmodule

FILE: src/line_arc_step_interpolator.sv
// ----------------------------------------------------------------------------
// line_arc_step_interpolator
// point-by-point comparison interpolator for lines and circular arcs
// ----------------------------------------------------------------------------
//
//  channel   direction  transaction
//  s_axis    in         load line / cw arc / ccw arc, or step request
//  m_axis    out        one step result for every step request
//  apb       in/out     arc_step_limit register at byte address 0
//
//  one item per clock sustained while m_axis accepts results; a step result
//  passes through the input register and then the result register
//  the decision for a step is made combinationally from the current position,
//  through the two shared multipliers in lasi_step
//  reset leaves the tool at the origin, no move active, limit at full scale
//  a stalled m_axis holds a step in the input register and s_axis backs up;
//  load transactions go through even while a result waits
//
// ----------------------------------------------------------------------------
module line_arc_step_interpolator
    import lasi_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // opcode, start_x, start_y, end_x, end_y, center_x, center_y, zero pad
    input  logic [((2 + 6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,

    // pos_x, pos_y, zero pad
    output logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0]     m_axis_tdata,
    // step_axis, step_negative, moved, overrun
    output logic [OUT_USER_W-1:0]   m_axis_tuser,
    output logic                    m_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int CW     = COORD_WIDTH;
    // deviation width: exact up to 30 bit coordinates, modulo 2^64 above
    localparam int FW     = (2 * CW + 4 > 64) ? 64 : 2 * CW + 4;
    // step counter holds a full line length or the arc limit
    localparam int SW     = (CW + 1 > LIMIT_W) ? CW + 1 : LIMIT_W;
    localparam int OUT_TW = ((2 * CW + 7) / 8) * 8;

    // input register
    logic          in_valid_reg;
    logic [1:0]    in_op_reg;
    logic [CW-1:0] in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg, in_cx_reg, in_cy_reg;

    // interpolator state
    logic [CW-1:0] cur_x_reg, cur_y_reg, org_x_reg, org_y_reg;
    logic [CW-1:0] tgt_x_reg, tgt_y_reg, ctr_x_reg, ctr_y_reg;
    logic [FW-1:0] radius_reg;
    logic [SW-1:0] steps_reg;
    logic [1:0]    mode_reg;
    logic          active_reg;

    // result register
    logic          out_valid_reg;
    logic [CW-1:0] out_x_reg, out_y_reg;
    step_flags_t   out_flags_reg;

    logic               is_step, advance, in_take;
    logic [LIMIT_W-1:0] arc_step_limit;
    logic [FW-1:0]      load_radius;
    logic [SW-1:0]      load_steps, step_steps;
    logic               load_active;
    logic [CW-1:0]      step_x, step_y;
    step_flags_t        step_flags;

    // the held item moves on when it is a load, or when the result slot frees up
    assign is_step       = (in_op_reg == OP_STEP);
    assign advance       = in_valid_reg && (!is_step || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    lasi_apb u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .arc_step_limit (arc_step_limit)
    );

    lasi_load #(
        .CW (CW),
        .FW (FW),
        .SW (SW)
    ) u_load (
        .opcode         (in_op_reg),
        .start_x        (in_sx_reg),
        .start_y        (in_sy_reg),
        .end_x          (in_ex_reg),
        .end_y          (in_ey_reg),
        .center_x       (in_cx_reg),
        .center_y       (in_cy_reg),
        .arc_step_limit (arc_step_limit),
        .radius_sq      (load_radius),
        .steps_init     (load_steps),
        .active_init    (load_active)
    );

    lasi_step #(
        .CW (CW),
        .FW (FW),
        .SW (SW)
    ) u_step (
        .mode       (mode_reg),
        .cur_x      (cur_x_reg),
        .cur_y      (cur_y_reg),
        .org_x      (org_x_reg),
        .org_y      (org_y_reg),
        .tgt_x      (tgt_x_reg),
        .tgt_y      (tgt_y_reg),
        .ctr_x      (ctr_x_reg),
        .ctr_y      (ctr_y_reg),
        .radius_sq  (radius_reg),
        .steps_rem  (steps_reg),
        .next_x     (step_x),
        .next_y     (step_y),
        .next_steps (step_steps),
        .flags      (step_flags)
    );

    // input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register: payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg <= s_axis_tdata[1:0];
            in_sx_reg <= s_axis_tdata[2 + 0 * CW +: CW];
            in_sy_reg <= s_axis_tdata[2 + 1 * CW +: CW];
            in_ex_reg <= s_axis_tdata[2 + 2 * CW +: CW];
            in_ey_reg <= s_axis_tdata[2 + 3 * CW +: CW];
            in_cx_reg <= s_axis_tdata[2 + 4 * CW +: CW];
            in_cy_reg <= s_axis_tdata[2 + 5 * CW +: CW];
        end
    end

    // move state: a load replaces any move, a step advances an active one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            ctr_x_reg  <= '0;
            ctr_y_reg  <= '0;
            radius_reg <= '0;
            steps_reg  <= '0;
            mode_reg   <= MODE_LINE;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (!is_step)
            begin
                cur_x_reg  <= in_sx_reg;
                cur_y_reg  <= in_sy_reg;
                org_x_reg  <= in_sx_reg;
                org_y_reg  <= in_sy_reg;
                tgt_x_reg  <= in_ex_reg;
                tgt_y_reg  <= in_ey_reg;
                ctr_x_reg  <= in_cx_reg;
                ctr_y_reg  <= in_cy_reg;
                radius_reg <= load_radius;
                steps_reg  <= load_steps;
                mode_reg   <= in_op_reg;
                active_reg <= load_active;
            end
            else if (active_reg)
            begin
                cur_x_reg  <= step_x;
                cur_y_reg  <= step_y;
                steps_reg  <= step_steps;
                active_reg <= !step_flags.last;
            end
        end
    end

    // result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register: payload, idle steps report the position with no flags
    always_ff @(posedge clk)
    begin
        if (advance && is_step)
        begin
            if (active_reg)
            begin
                out_x_reg     <= step_x;
                out_y_reg     <= step_y;
                out_flags_reg <= step_flags;
            end
            else
            begin
                out_x_reg     <= cur_x_reg;
                out_y_reg     <= cur_y_reg;
                out_flags_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'({out_y_reg, out_x_reg});
    assign m_axis_tlast  = out_flags_reg.last;
    assign m_axis_tuser  = {out_flags_reg.overrun, out_flags_reg.moved,
                            out_flags_reg.step_negative, out_flags_reg.step_axis};

endmodule
